>>> hw/rtl/cfn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfn_pkg - shared types and constants for camera frame navigation
// Fixed-point formats, register indexes, reset values and saturation helper.
// ----------------------------------------------------------------------------
package cfn_pkg;

    // fixed-point widths
    localparam int DATA_W = 32;
    localparam int ACC_W  = 66;
    localparam int SHR_W  = ACC_W - 30;
    localparam int SUM_W  = 37;

    localparam logic signed [DATA_W-1:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [DATA_W-1:0] NEG_ONE_Q30 = -32'sd1073741824;
    localparam logic signed [DATA_W-1:0] START_Z     = 32'sd2621440;
    localparam logic signed [ACC_W-1:0]  HALF_Q30    = 66'sd536870912;

    // configuration register indexes
    localparam logic [1:0] REG_MOVE_STEP = 2'd0;
    localparam logic [1:0] REG_COS_STEP  = 2'd1;
    localparam logic [1:0] REG_SIN_STEP  = 2'd2;

    localparam logic [30:0]             MOVE_STEP_RST = 31'd65536;
    localparam logic signed [DATA_W-1:0] COS_STEP_RST = 32'sd1073578288;
    localparam logic signed [DATA_W-1:0] SIN_STEP_RST = 32'sd18739379;

    // held control count and state vector slots
    localparam logic [3:0] KEY_COUNT = 4'd12;
    localparam logic [1:0] VEC_POS   = 2'd0;
    localparam logic [1:0] VEC_FWD   = 2'd1;
    localparam logic [1:0] VEC_UP    = 2'd2;
    localparam logic [1:0] VEC_RIGHT = 2'd3;

    // rotation axes (held_keys index divided by two)
    localparam logic [2:0] AXIS_ROLL  = 3'd3;
    localparam logic [2:0] AXIS_PITCH = 3'd4;
    localparam logic [2:0] AXIS_YAW   = 3'd5;

    // working copy of the configuration, angles already clamped
    typedef struct packed {
        logic [30:0]              move_step;
        logic signed [DATA_W-1:0] cos_step;
        logic signed [DATA_W-1:0] sin_step;
    } cfg_t;

    // multiply-accumulate command
    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } mac_req_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic same;
        begin
            same = (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}});
            if (same) begin
                sat32 = v[DATA_W-1:0];
            end else if (v[SUM_W-1]) begin
                sat32 = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                sat32 = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    endfunction

endpackage : cfn_pkg
`default_nettype wire

>>> hw/rtl/cfn_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfn_mac - bit-serial signed multiply-accumulate
// Shifts the multiplier out one bit per cycle and adds the shifted
// multiplicand into a wide accumulator.
// ----------------------------------------------------------------------------
module cfn_mac
    import cfn_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mac_req_t                 req,
    input  wire logic signed [DATA_W-1:0] x,
    input  wire logic signed [DATA_W-1:0] y,
    output logic                          busy,
    output logic                          done,
    output logic signed [ACC_W-1:0]       acc
);

    logic                    busy_reg,   busy_next;
    logic                    done_reg,   done_next;
    logic [4:0]              cnt_reg,    cnt_next;
    logic                    sub_reg,    sub_next;
    logic signed [ACC_W-1:0] mcand_reg,  mcand_next;
    logic [DATA_W-1:0]       mplier_reg, mplier_next;
    logic signed [ACC_W-1:0] acc_reg,    acc_next;
    logic                    op_sub;
    logic signed [ACC_W-1:0] addend;

    // the sign bit of the multiplier carries negative weight
    assign op_sub = sub_reg ^ (cnt_reg == 5'd31);

    always_comb begin
        if (!mplier_reg[0]) begin
            addend = '0;
        end else if (op_sub) begin
            addend = -mcand_reg;
        end else begin
            addend = mcand_reg;
        end
    end

    // serial step or load of a new product
    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        sub_next    = sub_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            sub_next    = req.sub;
            mcand_next  = ACC_W'(x);
            mplier_next = y;
            if (req.clear) begin
                acc_next = HALF_Q30;
            end
        end else if (busy_reg) begin
            acc_next    = acc_reg + addend;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sub_reg    <= sub_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign acc  = acc_reg;

endmodule : cfn_mac
`default_nettype wire

>>> hw/rtl/cfn_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfn_cfg - configuration registers
// APB-style register file for step distance and rotation cosine and sine;
// presents the angle terms clamped to plus or minus one.
// ----------------------------------------------------------------------------
module cfn_cfg
    import cfn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [30:0]              move_step_reg;
    logic signed [DATA_W-1:0] cos_step_reg;
    logic signed [DATA_W-1:0] sin_step_reg;
    logic                     wr_en;
    logic [1:0]               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_step_reg <= MOVE_STEP_RST;
            cos_step_reg  <= COS_STEP_RST;
            sin_step_reg  <= SIN_STEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MOVE_STEP: move_step_reg <= pwdata[30:0];
                REG_COS_STEP:  cos_step_reg  <= pwdata;
                REG_SIN_STEP:  sin_step_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (reg_idx)
            REG_MOVE_STEP: prdata = {1'b0, move_step_reg};
            REG_COS_STEP:  prdata = cos_step_reg;
            REG_SIN_STEP:  prdata = sin_step_reg;
            default:       prdata = '0;
        endcase
    end

    function automatic logic signed [DATA_W-1:0] clamp_unit(input logic signed [DATA_W-1:0] v);
        begin
            if (v > ONE_Q30) begin
                clamp_unit = ONE_Q30;
            end else if (v < NEG_ONE_Q30) begin
                clamp_unit = NEG_ONE_Q30;
            end else begin
                clamp_unit = v;
            end
        end
    endfunction

    assign cfg.move_step = move_step_reg;
    assign cfg.cos_step  = clamp_unit(cos_step_reg);
    assign cfg.sin_step  = clamp_unit(sin_step_reg);

endmodule : cfn_cfg
`default_nettype wire

>>> hw/rtl/camera_frame_navigation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// camera_frame_navigation - fly camera position and frame update
// Keeps a Q16.16 position and a Q2.30 forward/up/right frame and applies
// held movement and rotation controls one at a time on a serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel s_*: one transaction per frame; s_opcode 0 applies the
//    held controls in s_held_keys (bit 0 first), s_opcode 1 recenters
//  - result channel m_*: one transaction per input with position and frame
//  - APB port sets move_step (0x0), cos_step (0x4) and sin_step (0x8)
//  - every product runs through one bit-serial multiplier at one multiplier
//    bit per cycle
//  - one item is worked on at a time; s_ready is high while idle
//  - the result sits in an output register, so a new transaction is taken
//    while the previous result waits; a stalled receiver only holds the
//    final copy into the output register
//  - reset loads the start position (0, 0, 40) and the start frame and the
//    default step values
// ----------------------------------------------------------------------------
module camera_frame_navigation
    import cfn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [11:0] s_held_keys,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_pos_x,
    output logic [31:0]      m_pos_y,
    output logic [31:0]      m_pos_z,
    output logic [31:0]      m_fwd_x,
    output logic [31:0]      m_fwd_y,
    output logic [31:0]      m_fwd_z,
    output logic [31:0]      m_up_x,
    output logic [31:0]      m_up_y,
    output logic [31:0]      m_up_z,
    output logic [31:0]      m_right_x,
    output logic [31:0]      m_right_y,
    output logic [31:0]      m_right_z,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    cfg_t                     cfg;
    mac_req_t                 mac_req;
    logic signed [DATA_W-1:0] mac_x, mac_y;
    logic                     mac_busy, mac_done;
    logic signed [ACC_W-1:0]  mac_acc;

    logic [2:0]               state_reg;
    logic [3:0]               kidx_reg;
    logic [11:0]              keys_reg;
    logic [1:0]               sidx_reg;
    logic [1:0]               term_reg;
    logic signed [DATA_W-1:0] tmp_reg;
    logic signed [DATA_W-1:0] st_reg  [4][3];
    logic signed [DATA_W-1:0] out_reg [4][3];
    logic                     m_valid_reg;

    logic                     is_move, neg_move, neg_rot;
    logic [1:0]               vsel, ia, ib;
    logic signed [DATA_W-1:0] op_a, op_b;
    logic signed [DATA_W-1:0] pos_cur;
    logic signed [SHR_W-1:0]  shr;
    logic signed [SUM_W-1:0]  pos_sum;
    logic signed [DATA_W-1:0] rot_val;

    cfn_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfn_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mac_req),
        .x       (mac_x),
        .y       (mac_y),
        .busy    (mac_busy),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    // control decode: which vector, which pair, which sign
    assign is_move  = (kidx_reg < 4'd6);
    assign neg_move = (kidx_reg == 4'd1) || (kidx_reg == 4'd3) || (kidx_reg == 4'd4);
    assign neg_rot  = !kidx_reg[0];

    always_comb begin
        vsel = VEC_FWD;
        ia   = 2'd0;
        ib   = 2'd1;
        if (is_move) begin
            priority if (kidx_reg < 4'd2) begin
                vsel = VEC_FWD;
            end else if (kidx_reg < 4'd4) begin
                vsel = VEC_UP;
            end else begin
                vsel = VEC_RIGHT;
            end
        end else begin
            unique case (kidx_reg[3:1])
                AXIS_ROLL: begin
                    vsel = sidx_reg[0] ? VEC_RIGHT : VEC_UP;
                    ia   = 2'd0;
                    ib   = 2'd1;
                end
                AXIS_PITCH: begin
                    vsel = sidx_reg[0] ? VEC_UP : VEC_FWD;
                    ia   = 2'd2;
                    ib   = 2'd1;
                end
                AXIS_YAW: begin
                    vsel = sidx_reg[0] ? VEC_RIGHT : VEC_FWD;
                    ia   = 2'd0;
                    ib   = 2'd2;
                end
                default: begin
                    vsel = VEC_FWD;
                    ia   = 2'd0;
                    ib   = 2'd1;
                end
            endcase
        end
    end

    assign op_a    = is_move ? st_reg[vsel][sidx_reg] : st_reg[vsel][ia];
    assign op_b    = st_reg[vsel][ib];
    assign pos_cur = st_reg[VEC_POS][sidx_reg];

    // multiplier operands per term
    always_comb begin
        mac_req.start = (state_reg == ST_LOAD);
        mac_req.clear = is_move || !term_reg[0];
        mac_req.sub   = 1'b0;
        mac_x         = cfg.cos_step;
        mac_y         = op_a;
        if (is_move) begin
            mac_x = {1'b0, cfg.move_step};
            mac_y = op_a;
        end else begin
            unique case (term_reg)
                2'd0: begin
                    mac_x = cfg.cos_step;
                    mac_y = op_a;
                end
                2'd1: begin
                    mac_x       = cfg.sin_step;
                    mac_y       = op_b;
                    mac_req.sub = !neg_rot;
                end
                2'd2: begin
                    mac_x       = cfg.sin_step;
                    mac_y       = op_a;
                    mac_req.sub = neg_rot;
                end
                default: begin
                    mac_x = cfg.cos_step;
                    mac_y = op_b;
                end
            endcase
        end
    end

    // rounding shift and saturating update
    assign shr     = mac_acc[ACC_W-1:30];
    assign pos_sum = neg_move ? (SUM_W'(pos_cur) - SUM_W'(shr))
                              : (SUM_W'(pos_cur) + SUM_W'(shr));
    assign rot_val = sat32(SUM_W'(shr));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            kidx_reg             <= '0;
            sidx_reg             <= '0;
            term_reg             <= '0;
            m_valid_reg          <= 1'b0;
            st_reg[VEC_POS][0]   <= '0;
            st_reg[VEC_POS][1]   <= '0;
            st_reg[VEC_POS][2]   <= START_Z;
            st_reg[VEC_FWD][0]   <= '0;
            st_reg[VEC_FWD][1]   <= '0;
            st_reg[VEC_FWD][2]   <= NEG_ONE_Q30;
            st_reg[VEC_UP][0]    <= '0;
            st_reg[VEC_UP][1]    <= ONE_Q30;
            st_reg[VEC_UP][2]    <= '0;
            st_reg[VEC_RIGHT][0] <= ONE_Q30;
            st_reg[VEC_RIGHT][1] <= '0;
            st_reg[VEC_RIGHT][2] <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        keys_reg <= s_held_keys;
                        kidx_reg <= '0;
                        if (s_opcode) begin
                            st_reg[VEC_POS][0]   <= '0;
                            st_reg[VEC_POS][1]   <= '0;
                            st_reg[VEC_POS][2]   <= START_Z;
                            st_reg[VEC_FWD][0]   <= '0;
                            st_reg[VEC_FWD][1]   <= '0;
                            st_reg[VEC_FWD][2]   <= NEG_ONE_Q30;
                            st_reg[VEC_UP][0]    <= '0;
                            st_reg[VEC_UP][1]    <= ONE_Q30;
                            st_reg[VEC_UP][2]    <= '0;
                            st_reg[VEC_RIGHT][0] <= ONE_Q30;
                            st_reg[VEC_RIGHT][1] <= '0;
                            st_reg[VEC_RIGHT][2] <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    sidx_reg <= '0;
                    term_reg <= '0;
                    priority if (kidx_reg == KEY_COUNT) begin
                        state_reg <= ST_DONE;
                    end else if (keys_reg[kidx_reg]) begin
                        state_reg <= ST_LOAD;
                    end else begin
                        kidx_reg <= kidx_reg + 4'd1;
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (mac_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_LOAD;
                    if (is_move) begin
                        st_reg[VEC_POS][sidx_reg] <= sat32(pos_sum);
                        if (sidx_reg == 2'd2) begin
                            kidx_reg  <= kidx_reg + 4'd1;
                            state_reg <= ST_SCAN;
                        end else begin
                            sidx_reg <= sidx_reg + 2'd1;
                        end
                    end else begin
                        term_reg <= term_reg + 2'd1;
                        if (term_reg == 2'd1) begin
                            tmp_reg <= rot_val;
                        end
                        if (term_reg == 2'd3) begin
                            st_reg[vsel][ia] <= tmp_reg;
                            st_reg[vsel][ib] <= rot_val;
                            if (sidx_reg[0]) begin
                                kidx_reg  <= kidx_reg + 4'd1;
                                state_reg <= ST_SCAN;
                            end else begin
                                sidx_reg <= sidx_reg + 2'd1;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= st_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_pos_x   = out_reg[VEC_POS][0];
    assign m_pos_y   = out_reg[VEC_POS][1];
    assign m_pos_z   = out_reg[VEC_POS][2];
    assign m_fwd_x   = out_reg[VEC_FWD][0];
    assign m_fwd_y   = out_reg[VEC_FWD][1];
    assign m_fwd_z   = out_reg[VEC_FWD][2];
    assign m_up_x    = out_reg[VEC_UP][0];
    assign m_up_y    = out_reg[VEC_UP][1];
    assign m_up_z    = out_reg[VEC_UP][2];
    assign m_right_x = out_reg[VEC_RIGHT][0];
    assign m_right_y = out_reg[VEC_RIGHT][1];
    assign m_right_z = out_reg[VEC_RIGHT][2];

    // a product is never started while the multiplier is still shifting
    assert property (@(posedge aclk) disable iff (!aresetn)
        mac_req.start |-> !mac_busy)
        else $error("multiplier restarted while busy");

    // while waiting on a product the multiplier must be running or just done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (mac_busy || mac_done || $past(mac_req.start)))
        else $error("waiting on an idle multiplier");

    // the control index never runs past the control count
    assert property (@(posedge aclk) disable iff (!aresetn)
        kidx_reg <= KEY_COUNT)
        else $error("control index out of range");

    // an accepted transaction always leaves the idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("input transaction lost");

endmodule : camera_frame_navigation
`default_nettype wire
